// ----- design/acf_pkg.sv -----
`timescale 1ns / 1ps
package acf_pkg;

    // Q1.16 fade position
    localparam int PCT_W = 17;
    localparam logic [PCT_W-1:0] PCT_FULL = 17'h10000;

    // 8-bit channel magnitude times a Q1.16 position
    localparam int PROD_W = 25;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_START_COLOR  = 4'd0;
    localparam logic [ADDR_W-1:0] REG_TARGET_COLOR = 4'd1;
    localparam logic [ADDR_W-1:0] REG_FRAME_COUNT  = 4'd2;
    localparam logic [ADDR_W-1:0] REG_FADE_MODE    = 4'd3;

    localparam logic MODE_STEPPED = 1'b0;
    localparam logic MODE_PERCENT = 1'b1;

    localparam logic CMD_RESTART = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- design/acf_div.sv -----
`timescale 1ns / 1ps
module acf_div #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [7:0]               mag_in,
    input  logic [COUNT_BITS-1:0]    divisor,
    output logic [FRAC_BITS+7:0]     quot,
    output acf_pkg::unit_stat_t      stat
);

    localparam int QW    = FRAC_BITS + 8;
    localparam int CNT_W = $clog2(QW);

    logic [QW-1:0]         num_reg, num_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS:0]   trial;
    logic                  ge;

    // restoring division, one quotient bit per cycle, MSB first
    always_comb begin
        trial     = {rem_reg, num_reg[QW-1]};
        ge        = trial >= {1'b0, div_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = {mag_in, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            // a zero frame count counts as one frame
            div_next  = (divisor == '0) ? COUNT_BITS'(1) : divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[QW-2:0], ge};
            rem_next = ge ? COUNT_BITS'(trial - {1'b0, div_reg}) : trial[COUNT_BITS-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- design/acf_mul.sv -----
`timescale 1ns / 1ps
module acf_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [7:0]                   mag_in,
    input  logic [acf_pkg::PCT_W-1:0]    pct_in,
    output logic [acf_pkg::PROD_W-1:0]   prod,
    output acf_pkg::unit_stat_t          stat
);

    localparam int CNT_W = $clog2(acf_pkg::PCT_W);

    logic [7:0]                hi_reg, hi_next;
    logic [acf_pkg::PCT_W-1:0] lo_reg, lo_next;
    logic [7:0]                mag_reg, mag_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [8:0]                sum;

    // shift-add: one multiplier bit per cycle, product shifts down into lo
    always_comb begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mag_reg} : 9'd0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mag_next  = mag_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = pct_in;
            mag_next  = mag_in;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[8:1];
            lo_next  = {sum[0], lo_reg[acf_pkg::PCT_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(acf_pkg::PCT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mag_reg <= mag_next;
    end

    assign prod      = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- design/argb_color_fade_top.sv -----
`timescale 1ns / 1ps
// ARGB color fade. Program start_color, target_color, frame_count and fade_mode
// through the cfg channel (index 0..3) while the block is idle; the colors and
// frame_count apply at the next restart, fade_mode to each word taken while no
// stepped fade runs. Each word on the s_ channel (tuser = cmd, tdata = percent)
// gives exactly one word on the m_ channel (tdata = ARGB draw color,
// tuser = done flag). cmd restart: latch the colors and show the start color.
// In stepped mode each red, green and blue step is (target - start) /
// frame_count, from three bit-serial dividers running side by side, one
// quotient bit a cycle. cmd advance: while a stepped fade runs, add the
// steps and pin channels at the target; in percent mode otherwise, three
// shift-add multipliers walk the 17 bits of the position. Only one word
// is in work at a time. The result sits in an output register; a stalled
// receiver holds it there while the next input word is already taken and
// worked on, and that word then waits for the register to free up.
// Reset (synchronous, aresetn low) restores the register defaults, sets the
// color to opaque white and leaves no fade running.
module argb_color_fade_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [16:0] percent, [23:17] zero
    input  logic                        s_tuser,   // [0] cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] draw_color
    output logic                        m_tuser,   // [0] done_res
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [acf_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                 cfg_data
);

    localparam int VW     = FRAC_BITS + 8;
    localparam int NUM_W  = acf_pkg::PROD_W;
    localparam int WW     = NUM_W + FRAC_BITS;
    localparam int UP_SH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [VW-1:0] MAX_VAL = {8'hFF, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0] HALF    =
        {{(VW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    acf_pkg::state_t state_reg, state_next;

    logic [31:0]           start_reg, start_next;
    logic [31:0]           target_reg, target_next;
    logic [COUNT_BITS-1:0] frame_reg, frame_next;
    logic                  mode_reg, mode_next;
    logic [31:0]           lat_start_reg, lat_start_next;
    logic [31:0]           lat_target_reg, lat_target_next;
    logic [VW-1:0]         chan_value_reg [3];
    logic [VW-1:0]         chan_value_next [3];
    logic [VW-1:0]         step_reg [3];
    logic [VW-1:0]         step_next [3];
    logic [2:0]            down_reg, down_next;
    logic [7:0]            alpha_reg, alpha_next;
    logic                  running_reg, running_next;
    logic                  full_reg, full_next;
    logic [31:0]           m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  accept;
    logic                  cfg_write;
    logic                  div_start;
    logic                  mul_start;
    logic                  out_load;
    logic [acf_pkg::PCT_W-1:0] pct_sat;

    logic [7:0]            cfg_mag [3];
    logic [2:0]            cfg_down;
    logic [7:0]            lat_mag [3];
    logic [2:0]            lat_down;
    logic [VW-1:0]         tgt_fix [3];
    logic [VW-1:0]         span [3];
    logic [2:0]            fin;
    logic [VW-1:0]         tick_val [3];
    logic [NUM_W-1:0]      num [3];
    logic [WW-1:0]         wide [3];
    logic [VW-1:0]         rsum [3];
    logic [31:0]           draw;

    logic [VW-1:0]             div_quot [3];
    acf_pkg::unit_stat_t       div_stat [3];
    logic [NUM_W-1:0]          mul_prod [3];
    acf_pkg::unit_stat_t       mul_stat [3];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;
    // any position past full saturates to full
    assign pct_sat   = s_tdata[16] ? acf_pkg::PCT_FULL : s_tdata[acf_pkg::PCT_W-1:0];

    // per-channel arithmetic, red is lane 0
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cfg_down[ch] = target_reg[23-8*ch -: 8] < start_reg[23-8*ch -: 8];
            cfg_mag[ch]  = cfg_down[ch] ?
                start_reg[23-8*ch -: 8] - target_reg[23-8*ch -: 8] :
                target_reg[23-8*ch -: 8] - start_reg[23-8*ch -: 8];
            lat_down[ch] = lat_target_reg[23-8*ch -: 8] < lat_start_reg[23-8*ch -: 8];
            lat_mag[ch]  = lat_down[ch] ?
                lat_start_reg[23-8*ch -: 8] - lat_target_reg[23-8*ch -: 8] :
                lat_target_reg[23-8*ch -: 8] - lat_start_reg[23-8*ch -: 8];
            tgt_fix[ch]  = {lat_target_reg[23-8*ch -: 8], {FRAC_BITS{1'b0}}};

            // the accumulator never passes the target, so the distance is unsigned
            span[ch]     = down_reg[ch] ? chan_value_reg[ch] - tgt_fix[ch] :
                                          tgt_fix[ch] - chan_value_reg[ch];
            fin[ch]      = span[ch] <= step_reg[ch];
            tick_val[ch] = fin[ch] ? tgt_fix[ch] :
                           down_reg[ch] ? chan_value_reg[ch] - step_reg[ch] :
                                          chan_value_reg[ch] + step_reg[ch];

            // start * 1.0 +/- |diff| * position, never negative
            num[ch]  = lat_down[ch] ?
                {1'b0, lat_start_reg[23-8*ch -: 8], 16'h0000} - mul_prod[ch] :
                {1'b0, lat_start_reg[23-8*ch -: 8], 16'h0000} + mul_prod[ch];
            wide[ch] = (WW'(num[ch]) << UP_SH) >> DN_SH;

            rsum[ch] = chan_value_reg[ch] + HALF;
        end
        draw = {alpha_reg, rsum[0][VW-1:FRAC_BITS], rsum[1][VW-1:FRAC_BITS],
                rsum[2][VW-1:FRAC_BITS]};
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        acf_div #(
            .FRAC_BITS  (FRAC_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .mag_in  (cfg_mag[g]),
            .divisor (frame_reg),
            .quot    (div_quot[g]),
            .stat    (div_stat[g])
        );

        acf_mul u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (mul_start),
            .mag_in  (lat_mag[g]),
            .pct_in  (pct_sat),
            .prod    (mul_prod[g]),
            .stat    (mul_stat[g])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            acf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == acf_pkg::CMD_RESTART) begin
                        state_next = (mode_reg == acf_pkg::MODE_STEPPED) ?
                                     acf_pkg::ST_DIV : acf_pkg::ST_OUT;
                    end else if (running_reg) begin
                        state_next = acf_pkg::ST_TICK;
                    end else if (mode_reg == acf_pkg::MODE_PERCENT) begin
                        state_next = acf_pkg::ST_MUL;
                    end else begin
                        state_next = acf_pkg::ST_OUT;
                    end
                end
            end
            acf_pkg::ST_TICK: state_next = acf_pkg::ST_OUT;
            acf_pkg::ST_DIV: begin
                if (div_stat[0].done) state_next = acf_pkg::ST_OUT;
            end
            acf_pkg::ST_MUL: begin
                if (mul_stat[0].done) state_next = acf_pkg::ST_OUT;
            end
            acf_pkg::ST_OUT: begin
                if (out_load) state_next = acf_pkg::ST_IDLE;
            end
            default: state_next = acf_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            acf_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (s_tuser == acf_pkg::CMD_RESTART)
                            && (mode_reg == acf_pkg::MODE_STEPPED);
                mul_start = s_tvalid && (s_tuser != acf_pkg::CMD_RESTART)
                            && !running_reg && (mode_reg == acf_pkg::MODE_PERCENT);
            end
            acf_pkg::ST_OUT: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        start_next      = start_reg;
        target_next     = target_reg;
        frame_next      = frame_reg;
        mode_next       = mode_reg;
        lat_start_next  = lat_start_reg;
        lat_target_next = lat_target_reg;
        chan_value_next = chan_value_reg;
        step_next       = step_reg;
        down_next       = down_reg;
        alpha_next      = alpha_reg;
        running_next    = running_reg;
        full_next       = full_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (cfg_write) begin
            case (cfg_addr)
                acf_pkg::REG_START_COLOR:  start_next  = cfg_data;
                acf_pkg::REG_TARGET_COLOR: target_next = cfg_data;
                acf_pkg::REG_FRAME_COUNT:  frame_next  = COUNT_BITS'(cfg_data[15:0]);
                acf_pkg::REG_FADE_MODE:    mode_next   = cfg_data[0];
                default: ;
            endcase
        end

        if (accept) begin
            full_next = s_tdata[16];
            if (s_tuser == acf_pkg::CMD_RESTART) begin
                lat_start_next  = start_reg;
                lat_target_next = target_reg;
                alpha_next      = start_reg[31:24];
                down_next       = cfg_down;
                running_next    = (mode_reg == acf_pkg::MODE_STEPPED);
                for (int ch = 0; ch < 3; ch++) begin
                    chan_value_next[ch] = {start_reg[23-8*ch -: 8], {FRAC_BITS{1'b0}}};
                end
            end
        end

        case (state_reg)
            acf_pkg::ST_TICK: begin
                chan_value_next = tick_val;
                if (&fin) begin
                    alpha_next   = lat_target_reg[31:24];
                    running_next = 1'b0;
                end
            end
            acf_pkg::ST_DIV: begin
                if (div_stat[0].done) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        // a nonzero difference always moves by at least one LSB
                        step_next[ch] = (div_quot[ch] == '0 && lat_mag[ch] != 8'd0) ?
                                        VW'(1) : div_quot[ch];
                    end
                end
            end
            acf_pkg::ST_MUL: begin
                if (mul_stat[0].done) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        chan_value_next[ch] = wide[ch][VW-1:0];
                    end
                    if (full_reg) alpha_next = lat_target_reg[31:24];
                end
            end
            acf_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tdata_next  = draw;
                    m_tuser_next  = !running_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= acf_pkg::ST_IDLE;
            start_reg      <= 32'hFFFF_FFFF;
            target_reg     <= 32'hFFFF_FFFF;
            frame_reg      <= COUNT_BITS'(100);
            mode_reg       <= acf_pkg::MODE_STEPPED;
            lat_start_reg  <= 32'hFFFF_FFFF;
            lat_target_reg <= 32'hFFFF_FFFF;
            for (int ch = 0; ch < 3; ch++) begin
                chan_value_reg[ch] <= MAX_VAL;
                step_reg[ch]       <= '0;
            end
            down_reg       <= '0;
            alpha_reg      <= 8'hFF;
            running_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            target_reg     <= target_next;
            frame_reg      <= frame_next;
            mode_reg       <= mode_next;
            lat_start_reg  <= lat_start_next;
            lat_target_reg <= lat_target_next;
            chan_value_reg <= chan_value_next;
            step_reg       <= step_next;
            down_reg       <= down_next;
            alpha_reg      <= alpha_next;
            running_reg    <= running_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one word in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken while a word is in work");

    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat[1] == div_stat[0] && div_stat[2] == div_stat[0]
        && mul_stat[1] == mul_stat[0] && mul_stat[2] == mul_stat[0])
        else $error("serial lanes out of step");

    a_div_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == acf_pkg::ST_DIV |-> div_stat[0].busy || div_stat[0].done)
        else $error("waiting on an idle divider");

    a_mul_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat[0].done |-> state_reg == acf_pkg::ST_MUL)
        else $error("multiplier finished outside percent state");

    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chan_value_reg[0] <= MAX_VAL && chan_value_reg[1] <= MAX_VAL
        && chan_value_reg[2] <= MAX_VAL)
        else $error("channel accumulator above full scale");

endmodule

// ----- tb/fade_color_checker.sv -----
`timescale 1ns / 1ps
module fade_color_checker #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [23:0]                 s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [31:0]                 m_tdata,
    input  logic                        m_tuser,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [acf_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                 cfg_data,
    output int                          pending,
    output int                          errors
);

    localparam longint UNIT = longint'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [31:0] draw_color;
        logic        done_res;
    } fade_word_t;

    fade_word_t  draw_q[$];

    // register file as the block sees it
    logic [31:0] start_reg;
    logic [31:0] target_reg;
    logic [15:0] frame_reg;
    logic        mode_reg;

    // fade state
    logic [31:0] lat_start;
    logic [31:0] lat_target;
    longint      ch_level[3];
    longint      ch_step[3];
    logic [7:0]  alpha_cur;
    bit          fade_on;

    function automatic longint chan_of(logic [31:0] c, int ch);
        return longint'(c[(16 - 8 * ch) +: 8]);
    endfunction

    function automatic logic [7:0] byte_round(longint v);
        longint r;
        r = (v + (UNIT >>> 1)) / UNIT;
        if (v < 0) r = 0;
        if (r > 255) r = 255;
        return r[7:0];
    endfunction

    function automatic logic [31:0] draw_word();
        return {alpha_cur, byte_round(ch_level[0]), byte_round(ch_level[1]),
                byte_round(ch_level[2])};
    endfunction

    task automatic restart_fade();
        longint frames, d, mag;
        frames = (frame_reg == 0) ? 1 : longint'(frame_reg);
        lat_start  = start_reg;
        lat_target = target_reg;
        alpha_cur  = lat_start[31:24];
        for (int ch = 0; ch < 3; ch++) begin
            d   = chan_of(lat_target, ch) - chan_of(lat_start, ch);
            mag = ((d < 0) ? -d : d) * UNIT / frames;
            if (d != 0 && mag == 0) mag = 1;
            ch_level[ch] = chan_of(lat_start, ch) * UNIT;
            ch_step[ch]  = (mode_reg == acf_pkg::MODE_STEPPED) ?
                           ((d < 0) ? -mag : mag) : 0;
        end
        fade_on = (mode_reg == acf_pkg::MODE_STEPPED);
    endtask

    task automatic tick_fade();
        longint tgt, gap;
        bit pin, all_pinned;
        all_pinned = 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
            tgt = chan_of(lat_target, ch) * UNIT;
            gap = tgt - ch_level[ch];
            pin = (gap == 0) || (gap > 0 && ch_step[ch] >= gap) ||
                  (gap < 0 && ch_step[ch] <= gap);
            if (pin) ch_level[ch] = tgt;
            else ch_level[ch] = ch_level[ch] + ch_step[ch];
            all_pinned = all_pinned && pin;
        end
        if (all_pinned) begin
            alpha_cur = lat_target[31:24];
            fade_on   = 1'b0;
        end
    endtask

    task automatic apply_percent(logic [acf_pkg::PCT_W-1:0] pct_in);
        longint p, s, d, num;
        p = (pct_in > acf_pkg::PCT_FULL) ? longint'(acf_pkg::PCT_FULL) : longint'(pct_in);
        for (int ch = 0; ch < 3; ch++) begin
            s   = chan_of(lat_start, ch);
            d   = chan_of(lat_target, ch) - s;
            num = s * 65536 + d * p;
            ch_level[ch] = num * UNIT / 65536;
        end
        // full position snaps to the whole target color, alpha included
        if (p == longint'(acf_pkg::PCT_FULL)) begin
            for (int ch = 0; ch < 3; ch++)
                ch_level[ch] = chan_of(lat_target, ch) * UNIT;
            alpha_cur = lat_target[31:24];
        end
    endtask

    always @(posedge aclk) begin
        fade_word_t want;
        if (!aresetn) begin
            start_reg  = 32'hFFFF_FFFF;
            target_reg = 32'hFFFF_FFFF;
            frame_reg  = 16'd100;
            mode_reg   = acf_pkg::MODE_STEPPED;
            lat_start  = 32'hFFFF_FFFF;
            lat_target = 32'hFFFF_FFFF;
            for (int ch = 0; ch < 3; ch++) begin
                ch_level[ch] = 255 * UNIT;
                ch_step[ch]  = 0;
            end
            alpha_cur = 8'hFF;
            fade_on   = 1'b0;
            draw_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    acf_pkg::REG_START_COLOR:  start_reg  = cfg_data;
                    acf_pkg::REG_TARGET_COLOR: target_reg = cfg_data;
                    acf_pkg::REG_FRAME_COUNT:
                        frame_reg = cfg_data[15:0] & 16'((32'd1 << COUNT_BITS) - 1);
                    acf_pkg::REG_FADE_MODE:    mode_reg   = cfg_data[0];
                    default: ;
                endcase
            end
            // retire the word leaving before taking the one arriving
            if (m_tvalid && m_tready) begin
                if (draw_q.size() == 0) begin
                    $error("unexpected result word: draw_color %h done_res %b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = draw_q.pop_front();
                    if (m_tdata !== want.draw_color) begin
                        $error("draw_color: expected %h, actual %h", want.draw_color, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.done_res) begin
                        $error("done_res: expected %b, actual %b", want.done_res, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == acf_pkg::CMD_RESTART) restart_fade();
                else if (fade_on) tick_fade();
                else if (mode_reg == acf_pkg::MODE_PERCENT)
                    apply_percent(s_tdata[acf_pkg::PCT_W-1:0]);
                want.draw_color = draw_word();
                want.done_res   = !fade_on;
                draw_q.push_back(want);
            end
        end
        pending = draw_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

    localparam logic CMD_ADVANCE = ~acf_pkg::CMD_RESTART;
    localparam int   WORD_TARGET = 1850;
    localparam int   CYCLE_LIMIT = 800000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [acf_pkg::ADDR_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_data  = '0;

    int          pending;
    int          errors;
    int          words_sent = 0;
    int          cycles     = 0;
    logic        quiet      = 1'b0;
    logic        hold_req   = 1'b0;
    int          hold_left  = 0;
    bit          hold_taken = 1'b0;

    always #4 aclk = ~aclk;

    argb_color_fade_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    fade_color_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_taken) begin
            m_tready <= 1'b0;
            hold_left  = 400;
            hold_taken = 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    // leaves tvalid high after the handshake; the next call or drain() decides
    task automatic send_word(input logic cmd, input logic [acf_pkg::PCT_W-1:0] pct);
        while (!quiet && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, pct};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        quiet <= (words_sent >= 1100 && words_sent < 1400);
        if (words_sent == 500) hold_req <= 1'b1;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [31:0] start_c, input logic [31:0] target_c,
                            input logic [15:0] frames, input logic mode);
        logic [acf_pkg::ADDR_W-1:0] addrs[4];
        logic [31:0] vals[4];
        addrs = '{acf_pkg::REG_START_COLOR, acf_pkg::REG_TARGET_COLOR,
                  acf_pkg::REG_FRAME_COUNT, acf_pkg::REG_FADE_MODE};
        vals  = '{start_c, target_c, {16'd0, frames}, {31'd0, mode}};
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_color();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_frames();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd1;
        if (r < 75) return 16'($urandom_range(2, 24));
        if (r < 90) return 16'($urandom_range(25, 300));
        if (r < 97) return 16'hFFFF;
        return 16'd0;
    endfunction

    function automatic logic [acf_pkg::PCT_W-1:0] pick_percent();
        int r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 30) return acf_pkg::PCT_FULL;
        if (r < 50) return acf_pkg::PCT_W'($urandom_range(0, 131071));
        return acf_pkg::PCT_W'($urandom_range(0, 65536));
    endfunction

    initial begin
        logic [31:0] start_c, target_c;
        logic [15:0] frames;
        logic        mode;
        int          n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: tick with nothing running, then a white-to-white fade
        send_word(CMD_ADVANCE, '0);
        send_word(acf_pkg::CMD_RESTART, '0);
        send_word(CMD_ADVANCE, '0);

        // short stepped fade with a one-count channel, then a position in stepped mode
        set_regs(32'h10FF_0080, 32'hE000_FF7F, 16'd3, acf_pkg::MODE_STEPPED);
        send_word(acf_pkg::CMD_RESTART, '0);
        repeat (4) send_word(CMD_ADVANCE, '0);
        send_word(CMD_ADVANCE, 17'h1FFFF);

        // zero frame count acts as one frame
        set_regs(32'h0000_0000, 32'hFFFF_FFFF, 16'd0, acf_pkg::MODE_STEPPED);
        send_word(acf_pkg::CMD_RESTART, '0);
        send_word(CMD_ADVANCE, '0);
        send_word(CMD_ADVANCE, '0);

        // longest fade; switch to percent mode while it still runs
        set_regs(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, acf_pkg::MODE_STEPPED);
        send_word(acf_pkg::CMD_RESTART, '0);
        send_word(CMD_ADVANCE, '0);
        set_regs(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, acf_pkg::MODE_PERCENT);
        send_word(CMD_ADVANCE, 17'h08000);
        send_word(CMD_ADVANCE, 17'h08000);

        // percent mode across the position range, saturation included
        set_regs(32'hFF00_0000, 32'h00FF_FFFF, 16'd2, acf_pkg::MODE_PERCENT);
        send_word(acf_pkg::CMD_RESTART, '0);
        send_word(CMD_ADVANCE, 17'h00000);
        send_word(CMD_ADVANCE, 17'h00001);
        send_word(CMD_ADVANCE, 17'h08000);
        send_word(CMD_ADVANCE, 17'h0FFFF);
        send_word(CMD_ADVANCE, acf_pkg::PCT_FULL);
        send_word(CMD_ADVANCE, 17'h10001);
        send_word(CMD_ADVANCE, 17'h1FFFF);
        send_word(CMD_ADVANCE, 17'h0FFFF);

        while (words_sent < WORD_TARGET) begin
            start_c  = pick_color();
            target_c = ($urandom_range(4) == 0) ? start_c ^ ($urandom & 32'h0303_0303)
                                                : pick_color();
            frames   = pick_frames();
            mode     = ($urandom_range(9) < 6) ? acf_pkg::MODE_STEPPED
                                               : acf_pkg::MODE_PERCENT;
            set_regs(start_c, target_c, frames, mode);

            // now and then carry on without a restart, so a mode switch lands mid-fade
            if ($urandom_range(9) != 0) send_word(acf_pkg::CMD_RESTART, '0);

            if (mode == acf_pkg::MODE_STEPPED)
                n = ((frames > 60) ? 60 : frames) + $urandom_range(0, 3);
            else n = $urandom_range(5, 25);

            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0)
                    send_word(1'($urandom_range(1)),
                              acf_pkg::PCT_W'($urandom_range(0, 131071)));
                else if (mode == acf_pkg::MODE_STEPPED)
                    send_word(CMD_ADVANCE, acf_pkg::PCT_W'($urandom_range(0, 131071)));
                else
                    send_word(CMD_ADVANCE, pick_percent());
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
